/* hdl/ehp_pkg.sv */
// Shared types and constants for the EBML element header parser.
// Used by ehp_vint_dec, ehp_result_stage and ebml_element_header_parser_core.
package ehp_pkg;

	// Longest variable-length integer accepted, in bytes (1 to 8)
	localparam int unsigned MAX_VINT_BYTES = 8;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OFF_W    = 32;
	localparam int unsigned ID_W     = 64;
	localparam int unsigned SIZE_W   = 56;
	localparam int unsigned HLEN_W   = 5;
	localparam int unsigned CNT_W    = 3;

	// Stream widths
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 216;
	localparam int unsigned M_USER_W = 3;

	// Bit positions in the result tuser
	localparam int unsigned U_UNKNOWN  = 0;
	localparam int unsigned U_OVERFLOW = 1;
	localparam int unsigned U_BAD      = 2;

	// Decoder to result stage: what one item leaves for the output register
	typedef struct packed {
		logic                    emit;
		logic                    bad;
		logic [ID_W-1:0]         id;
		logic [SIZE_W-1:0]       size;
		logic [OFF_W-1:0]        pay_off;
		logic [HLEN_W-1:0]       hdr_len;
	} ehp_res_t;

endpackage

/* hdl/ehp_vint_dec.sv */
// Byte-wise vint decoder for the EBML element header parser: ID, then size.
// Holds the header state; depends on ehp_pkg.
module ehp_vint_dec (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [ehp_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         element_start,
	input  logic [ehp_pkg::OFF_W-1:0]    start_offset,
	output ehp_pkg::ehp_res_t            res
);

	logic                          in_size_q;
	logic [ehp_pkg::CNT_W-1:0]     bif_q;
	logic [ehp_pkg::HLEN_W-1:0]    hl_q;
	logic [ehp_pkg::OFF_W-1:0]     held_start_q;
	logic [ehp_pkg::ID_W-1:0]      acc_q;
	logic [ehp_pkg::ID_W-1:0]      held_id_q;

	logic                          eff_in_size;
	logic [ehp_pkg::CNT_W-1:0]     eff_bif;
	logic [ehp_pkg::HLEN_W-1:0]    eff_hl;
	logic [ehp_pkg::OFF_W-1:0]     eff_start;
	logic [ehp_pkg::HLEN_W-1:0]    hl_new;
	logic [ehp_pkg::CNT_W-1:0]     lz;
	logic                          first;
	logic                          bad;
	logic [ehp_pkg::BYTE_W-1:0]    marker;
	logic [ehp_pkg::BYTE_W-1:0]    lead_byte;
	logic [ehp_pkg::ID_W-1:0]      acc_n;
	logic [ehp_pkg::CNT_W-1:0]     bif_n;
	logic                          done;
	logic                          size_done;
	logic [ehp_pkg::OFF_W-1:0]     pay_off;

	// Next-state and result logic for one byte
	always_comb begin
		// element_start drops any partial header
		eff_in_size = in_size_q & ~element_start;
		eff_bif     = element_start ? '0 : bif_q;
		eff_hl      = element_start ? '0 : hl_q;
		eff_start   = element_start ? start_offset : held_start_q;
		hl_new      = eff_hl + 5'd1;

		// leading zero count of the byte (highest set bit wins)
		lz = '0;
		for (int i = 0; i < 8; i++) begin
			if (data_byte[i]) begin
				lz = 3'(7 - i);
			end
		end

		first  = (eff_bif == '0);
		bad    = first && ((data_byte == 8'h00) ||
			({1'b0, lz} >= 4'(ehp_pkg::MAX_VINT_BYTES)));
		marker = 8'h80 >> lz;
		lead_byte = eff_in_size ? (data_byte & ~marker) : data_byte;

		if (first) begin
			acc_n = {56'd0, lead_byte};
			bif_n = lz;
		end else begin
			acc_n = {acc_q[55:0], data_byte};
			bif_n = eff_bif - 3'd1;
		end

		done      = !bad && (bif_n == '0);
		size_done = done && eff_in_size;
		pay_off   = eff_start + {27'd0, hl_new};

		res.emit    = bad || size_done;
		res.bad     = bad;
		res.id      = held_id_q;
		res.size    = acc_n[ehp_pkg::SIZE_W-1:0];
		res.pay_off = pay_off;
		res.hdr_len = hl_new;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_size_q    <= 1'b0;
			bif_q        <= '0;
			hl_q         <= '0;
			held_start_q <= '0;
		end else if (fire) begin
			priority if (bad || size_done) begin
				// header finished or broken: next bytes start a new ID
				in_size_q    <= 1'b0;
				bif_q        <= '0;
				hl_q         <= '0;
				held_start_q <= pay_off;
			end else if (done) begin
				// ID complete, size field follows
				in_size_q    <= 1'b1;
				bif_q        <= '0;
				hl_q         <= hl_new;
				held_start_q <= eff_start;
			end else begin
				in_size_q    <= eff_in_size;
				bif_q        <= bif_n;
				hl_q         <= hl_new;
				held_start_q <= eff_start;
			end
		end
	end

	// Accumulator and held ID
	always_ff @(posedge clk) begin
		if (fire) begin
			acc_q <= acc_n;
			if (done && !eff_in_size) begin
				held_id_q <= acc_n;
			end
		end
	end

endmodule

/* hdl/ehp_result_stage.sv */
// Result arithmetic and output register of the EBML element header parser.
// Depends on ehp_pkg.
module ehp_result_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  ehp_pkg::ehp_res_t               res,
	input  logic                            m_axis_tready,
	output logic                            m_axis_tvalid,
	output logic [ehp_pkg::M_DATA_W-1:0]    m_axis_tdata,
	output logic [ehp_pkg::M_USER_W-1:0]    m_axis_tuser
);

	logic                            valid_s2;
	logic [ehp_pkg::M_DATA_W-1:0]    data_s2;
	logic [ehp_pkg::M_USER_W-1:0]    user_s2;

	logic                            unknown;
	logic [ehp_pkg::OFF_W-1:0]       whole;
	logic [ehp_pkg::OFF_W:0]         fin_sum;
	logic                            overflow;
	logic [ehp_pkg::M_DATA_W-1:0]    data_n;
	logic [ehp_pkg::M_USER_W-1:0]    user_n;

	// Sizes and offsets of a finished header
	always_comb begin
		unknown  = (res.size == {ehp_pkg::SIZE_W{1'b1}});
		whole    = {27'd0, res.hdr_len} + res.size[31:0];
		fin_sum  = {1'b0, res.pay_off} + {1'b0, res.size[31:0]};
		overflow = (|res.size[55:32]) | fin_sum[32];

		if (res.bad) begin
			data_n = '0;
			user_n = '0;
			user_n[ehp_pkg::U_BAD] = 1'b1;
		end else if (unknown) begin
			data_n = {32'hFFFF_FFFF, 32'hFFFF_FFFF, res.pay_off, res.size, res.id};
			user_n = '0;
			user_n[ehp_pkg::U_UNKNOWN] = 1'b1;
		end else begin
			data_n = {fin_sum[31:0], whole, res.pay_off, res.size, res.id};
			user_n = '0;
			user_n[ehp_pkg::U_OVERFLOW] = overflow;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load && res.emit) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load && res.emit) begin
			data_s2 <= data_n;
			user_s2 <= user_n;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = user_s2;

endmodule

/* hdl/ebml_element_header_parser_core.sv */
// Top level of the EBML element header parser: input register, decoder, result stage.
// Depends on ehp_pkg, ehp_vint_dec and ehp_result_stage.
//
// Usage:
//   Header bytes enter on the s_axis channel, one item per byte. tuser set
//   marks the first byte of a new element and loads its buffer offset from
//   tdata; without it a header continues, or a new one begins at the previous
//   payload offset (child element). The element ID is decoded with its length
//   marker kept, then the data size with the marker removed.
//   One result leaves on m_axis after the last size byte, or at once for a
//   leading zero byte (bad marker flag, all other fields zero).
//   A result passes through the input register and then the output register;
//   the output register loads when the input register advances, which waits
//   while a held result is stalled.
//   Throughput: one byte per cycle while the output register has room, set by
//   the single decode step between the input register and the output register.
//   Reset clears the header state and the held start offset to zero and
//   empties both registers. When the receiver stalls with a result held, the
//   input register still takes one more byte; that byte, whether or not it
//   causes a result, waits in the input register until the held one is taken.
module ebml_element_header_parser_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] data_byte, [39:8] start_offset
	input  logic [ehp_pkg::S_DATA_W-1:0]    s_axis_tdata,
	// [0] element_start
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [63:0] element_id, [119:64] payload_size, [151:120] payload_offset,
	// [183:152] whole_size, [215:184] finish_offset
	output logic [ehp_pkg::M_DATA_W-1:0]    m_axis_tdata,
	// [0] size_unknown, [1] size_overflow, [2] bad_marker
	output logic [ehp_pkg::M_USER_W-1:0]    m_axis_tuser
);

	logic                          valid_s1;
	logic [ehp_pkg::BYTE_W-1:0]    byte_s1;
	logic                          start_s1;
	logic [ehp_pkg::OFF_W-1:0]     offset_s1;
	logic                          adv;
	logic                          fire;
	logic                          in_acc;
	ehp_pkg::ehp_res_t             res;

	// Input register advances whenever the output register has room
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign fire          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1   <= s_axis_tdata[7:0];
			offset_s1 <= s_axis_tdata[39:8];
			start_s1  <= s_axis_tuser;
		end
	end

	ehp_vint_dec u_dec (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.data_byte     (byte_s1),
		.element_start (start_s1),
		.start_offset  (offset_s1),
		.res           (res)
	);

	ehp_result_stage u_res (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire),
		.res           (res),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// A bad-marker result carries nothing but its flag
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[ehp_pkg::U_BAD] |->
			(m_axis_tdata == '0) && !m_axis_tuser[ehp_pkg::U_UNKNOWN] &&
			!m_axis_tuser[ehp_pkg::U_OVERFLOW])
		else $error("bad marker result with nonzero fields");

	// Unknown size never flags overflow and reports all-ones sizes
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[ehp_pkg::U_UNKNOWN] |->
			!m_axis_tuser[ehp_pkg::U_OVERFLOW] &&
			(m_axis_tdata[215:152] == {64{1'b1}}))
		else $error("unknown size result inconsistent");

	// Input stalls only when a byte waits behind a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a held result");

	// A held result that is not taken stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

endmodule
